FILE: hdl/gpio_with_edge_level_interrupts_unit_macros.svh
// Assertion macros used by the checker.
`ifndef GPIO_WITH_EDGE_LEVEL_INTERRUPTS_UNIT_MACROS_SVH
`define GPIO_WITH_EDGE_LEVEL_INTERRUPTS_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define GPIOEI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpioei: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define GPIOEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpioei: next-cycle check failed");

`endif

FILE: hdl/gpioei_pkg.sv
`timescale 1ns / 1ps

package gpioei_pkg;

  localparam int unsigned NumPins   = 32;
  localparam int unsigned IdxWidth  = 6;
  localparam int unsigned InUserW   = 1 + IdxWidth;
  localparam int unsigned InDataW   = NumPins;
  localparam int unsigned OutDataW  = 40;

  typedef logic [NumPins-1:0]  pins_t;
  typedef logic [IdxWidth-1:0] idx_t;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam idx_t RegDir  = 6'd0;
  localparam idx_t RegOut  = 6'd1;
  localparam idx_t RegIn   = 6'd2;
  localparam idx_t RegIe   = 6'd3;
  localparam idx_t RegIs   = 6'd4;
  localparam idx_t RegTrig = 6'd5;
  localparam idx_t RegPol  = 6'd6;

endpackage

FILE: hdl/gpio_with_edge_level_interrupts_unit.sv
`timescale 1ns / 1ps

// 32-pin GPIO register block with edge and level interrupts. Each input item is one
// register access (read or write of word 0..6: direction, output, input, irq enable,
// irq status (write 1 to clear), trigger mode (1 = level), polarity); every item
// returns one result item carrying the read data (0 for writes and unknown words)
// and the interrupt line after the access. An item is registered on entry, then
// executed against the register file and its result registered, so a new item is
// taken every cycle when the output is not stalled. The register file resets to all
// zeros.
module gpio_with_edge_level_interrupts_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gpioei_pkg::InDataW-1:0]  s_axis_tdata,  // [31:0] write_data
  input  logic [gpioei_pkg::InUserW-1:0]  s_axis_tuser,  // [0] opcode, [6:1] word_index
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gpioei_pkg::OutDataW-1:0] m_axis_tdata   // [31:0] read_data, [32] irq_level
);
  import gpioei_pkg::*;

  logic  in_valid_q;
  logic  in_op_q;
  idx_t  in_idx_q;
  pins_t in_data_q;

  logic  out_valid_q;
  pins_t out_rd_q;
  logic  out_irq_q;

  pins_t dir_q, out_q, in_q, ie_q, is_q, trig_q, pol_q;
  pins_t dir_n, outl_n, ie_n, is_n, trig_n, pol_n;
  pins_t outl_s, in_s, is_s;
  pins_t rd_d;
  logic  irq_d;
  logic  advance;
  logic  do_write;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign do_write      = advance && (in_op_q == OpWrite);

  always_comb begin
    dir_n  = dir_q;
    outl_n = out_q;
    ie_n   = ie_q;
    is_n   = is_q;
    trig_n = trig_q;
    pol_n  = pol_q;
    unique case (in_idx_q)
      RegDir:  dir_n = in_data_q;
      RegOut: begin
        is_n   = is_q | (ie_q & ~trig_q & (out_q ^ in_data_q) & ~(in_data_q ^ pol_q));
        outl_n = in_data_q;
      end
      RegIe:   ie_n   = in_data_q;
      RegIs:   is_n   = is_q & ~in_data_q;
      RegTrig: trig_n = in_data_q;
      RegPol:  pol_n  = in_data_q;
      default: ;
    endcase
    // pin settling after any write
    outl_s = outl_n & dir_n;
    in_s   = (in_q & ~dir_n) | outl_s;
    is_s   = (is_n & ~trig_n) | (trig_n & ie_n & ~(in_s ^ pol_n));
  end

  always_comb begin
    unique case (in_idx_q)
      RegDir:  rd_d = dir_q;
      RegOut:  rd_d = out_q;
      RegIn:   rd_d = in_q;
      RegIe:   rd_d = ie_q;
      RegIs:   rd_d = is_q;
      RegTrig: rd_d = trig_q;
      RegPol:  rd_d = pol_q;
      default: rd_d = '0;
    endcase
    if (in_op_q == OpWrite) begin
      rd_d  = '0;
      irq_d = |(is_s & ie_n);
    end else begin
      irq_d = |(is_q & ie_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dir_q       <= '0;
      out_q       <= '0;
      in_q        <= '0;
      ie_q        <= '0;
      is_q        <= '0;
      trig_q      <= '0;
      pol_q       <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (do_write) begin
        dir_q  <= dir_n;
        out_q  <= outl_s;
        in_q   <= in_s;
        ie_q   <= ie_n;
        is_q   <= is_s;
        trig_q <= trig_n;
        pol_q  <= pol_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser[0];
      in_idx_q  <= s_axis_tuser[IdxWidth:1];
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_rd_q  <= rd_d;
      out_irq_q <= irq_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - NumPins - 1){1'b0}}, out_irq_q, out_rd_q};

endmodule

FILE: hdl/gpioei_checker.sv
`timescale 1ns / 1ps
`include "gpio_with_edge_level_interrupts_unit_macros.svh"

module gpioei_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [gpioei_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [gpioei_pkg::InUserW-1:0]  s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gpioei_pkg::OutDataW-1:0] m_axis_tdata
);
  import gpioei_pkg::*;

  logic [1:0] pending_q;
  logic       in_acc;
  logic       out_acc;
  logic       unused_in;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  `GPIOEI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `GPIOEI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `GPIOEI_ASSERT_NOW(a_no_spurious, clk_i, rst_ni, m_axis_tvalid, pending_q != 2'd0 || unused_in != unused_in)
  `GPIOEI_ASSERT_NOW(a_depth, clk_i, rst_ni, pending_q == 2'd2, !s_axis_tready || m_axis_tready)
  `GPIOEI_ASSERT_NOW(a_idle_ready, clk_i, rst_ni, pending_q == 2'd0, s_axis_tready)

endmodule

bind gpio_with_edge_level_interrupts_unit gpioei_checker u_gpioei_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gpioei_pkg::*;

  localparam idx_t RegFirstBad = RegPol + 6'd1;
  localparam idx_t RegLastBad  = 6'd63;
  localparam int unsigned PhaseItems = 400;
  localparam int unsigned NumPhases  = 4;

  typedef struct packed {
    logic  op;
    idx_t  idx;
    pins_t data;
  } access_t;

  typedef struct packed {
    pins_t rdata;
    logic  irq;
  } access_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [31:0] write_data
  logic [InUserW-1:0]  s_axis_tuser = '0;   // [0] opcode, [6:1] word_index
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [31:0] read_data, [32] irq_level

  access_t     pend_q[$];
  access_rsp_t rsp_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned rd_cnt = 0;
  int unsigned wr_cnt = 0;
  int unsigned irq_cnt = 0;

  // predicted register file
  pins_t dir_q = '0, out_q = '0, in_q = '0, ie_q = '0, is_q = '0, level_q = '0, pol_q = '0;

  gpio_with_edge_level_interrupts_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic access_rsp_t gpio_access(access_t a);
    access_rsp_t r;
    pins_t hit;
    r.rdata = '0;
    if (a.op == OpWrite) begin
      case (a.idx)
        RegDir:  dir_q = a.data;
        RegOut: begin
          // edge hit uses the unmasked written value against the old latch
          hit = ie_q & ~level_q & (out_q ^ a.data) & ~(a.data ^ pol_q);
          is_q = is_q | hit;
          out_q = a.data;
        end
        RegIe:   ie_q = a.data;
        RegIs:   is_q = is_q & ~a.data;
        RegTrig: level_q = a.data;
        RegPol:  pol_q = a.data;
        default: ;
      endcase
      out_q = out_q & dir_q;
      in_q = (in_q & ~dir_q) | out_q;
      is_q = (is_q & ~level_q) | (level_q & ie_q & ~(in_q ^ pol_q));
    end else begin
      case (a.idx)
        RegDir:  r.rdata = dir_q;
        RegOut:  r.rdata = out_q;
        RegIn:   r.rdata = in_q;
        RegIe:   r.rdata = ie_q;
        RegIs:   r.rdata = is_q;
        RegTrig: r.rdata = level_q;
        RegPol:  r.rdata = pol_q;
        default: r.rdata = '0;
      endcase
    end
    r.irq = |(is_q & ie_q);
    return r;
  endfunction

  function automatic access_t mk_access(logic op, idx_t idx, pins_t data);
    access_t a;
    a.op = op;
    a.idx = idx;
    a.data = data;
    return a;
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int unsigned sel;
    sel = $urandom_range(99);
    a.op = (sel < 35) ? OpRead : OpWrite;
    sel = $urandom_range(99);
    if (sel < 8)
      a.idx = idx_t'($urandom_range(63));
    else if (sel < 30)
      a.idx = RegOut;
    else
      a.idx = idx_t'($urandom_range(6));
    sel = $urandom_range(99);
    if (sel < 55)
      a.data = $urandom;
    else if (sel < 65)
      a.data = '0;
    else if (sel < 75)
      a.data = '1;
    else
      a.data = pins_t'(1) << $urandom_range(31);
    return a;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    access_t a;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        a = pend_q.pop_front();
        rsp_q.push_back(gpio_access(a));
        if (a.op == OpWrite) wr_cnt++;
        else rd_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pend_q[0].data;
          s_axis_tuser  <= {pend_q[0].idx, pend_q[0].op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    access_rsp_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rsp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item, got rdata=%08h irq=%0b", $realtime,
                   m_axis_tdata[31:0], m_axis_tdata[32]);
        end else begin
          e = rsp_q.pop_front();
          if (m_axis_tdata[32]) irq_cnt++;
          if (m_axis_tdata[31:0] !== e.rdata) begin
            err_cnt++;
            $display("%0t: read_data mismatch, expected %08h got %08h", $realtime,
                     e.rdata, m_axis_tdata[31:0]);
          end
          if (m_axis_tdata[32] !== e.irq) begin
            err_cnt++;
            $display("%0t: irq_level mismatch, expected %0b got %0b", $realtime,
                     e.irq, m_axis_tdata[32]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values, invalid words
    for (int i = 0; i <= 6; i++) pend_q.push_back(mk_access(OpRead, idx_t'(i), '0));
    pend_q.push_back(mk_access(OpRead, RegFirstBad, '1));
    pend_q.push_back(mk_access(OpRead, RegLastBad, '1));
    // edge pins in the low half, level pins in the high half
    pend_q.push_back(mk_access(OpWrite, RegDir, '1));
    pend_q.push_back(mk_access(OpWrite, RegPol, 32'h0F0F_0F0F));
    pend_q.push_back(mk_access(OpWrite, RegTrig, 32'hFFFF_0000));
    pend_q.push_back(mk_access(OpWrite, RegIe, '1));
    pend_q.push_back(mk_access(OpWrite, RegOut, 32'hAAAA_5555));
    pend_q.push_back(mk_access(OpRead, RegIs, '0));
    pend_q.push_back(mk_access(OpWrite, RegIs, 32'h0000_FFFF));
    pend_q.push_back(mk_access(OpWrite, RegIn, 32'h1234_5678));
    pend_q.push_back(mk_access(OpWrite, RegLastBad, '1));
    // output written to pins that are inputs: masked off, but edges still count
    pend_q.push_back(mk_access(OpWrite, RegDir, 32'h00FF_00FF));
    pend_q.push_back(mk_access(OpWrite, RegOut, '1));
    pend_q.push_back(mk_access(OpRead, RegOut, '0));
    pend_q.push_back(mk_access(OpRead, RegIn, '0));
    pend_q.push_back(mk_access(OpRead, RegIs, '0));
    pend_q.push_back(mk_access(OpWrite, RegIs, '1));
    pend_q.push_back(mk_access(OpWrite, RegIe, '0));
    pend_q.push_back(mk_access(OpRead, RegFirstBad, '0));

    for (int ph = 0; ph < NumPhases; ph++) begin
      while (pend_q.size() != 0 || rsp_q.size() != 0) @(posedge clk_i);
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 68) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 68) : 0;
      for (int i = 0; i < PhaseItems; i++) pend_q.push_back(rand_access());
    end
    while (pend_q.size() != 0 || rsp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d register reads and %0d writes over %0d pacing phases;",
             rd_cnt, wr_cnt, NumPhases);
    $display("interrupt line was high in %0d result items.", irq_cnt);
    if (err_cnt == 0 && rsp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d items pending, %0d results outstanding",
             pend_q.size(), rsp_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
